// ===== src/itoa_pkg.sv =====
// itoa_pkg: shared types, constants and digit character function for the integer to ascii core
// no dependencies; compiled before every other file in src

package itoa_pkg;

    localparam int MAX_CHARS_DEF = 64;
    localparam int RESULT_CAP    = 64;
    localparam int ADDR_W        = $clog2(RESULT_CAP);
    localparam int CNT_W         = $clog2(RESULT_CAP) + 1;
    localparam int VALUE_W       = 64;
    localparam int NARROW_W      = 32;
    localparam int RADIX_W       = 5;
    localparam int DIGIT_W       = 4;
    localparam int CHAR_W        = 8;
    localparam int MINLEN_W      = 7;
    localparam int DIV_BITS      = 4;
    localparam int DIV_CYCLES    = VALUE_W / DIV_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      wide;
        logic [RADIX_W-1:0]        radix;
        logic                      upper_case;
        logic [MINLEN_W-1:0]       min_length;
        logic [CHAR_W-1:0]         fill_char;
        logic                      signed_mode;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last;
    } out_item_t;

    typedef enum logic [1:0] {
        SH_1 = 2'd0,
        SH_3 = 2'd1,
        SH_4 = 2'd2
    } shift_t;

    typedef struct packed {
        logic load;
        logic step;
        logic slice;
        logic clr_rem;
    } div_ctrl_t;

    typedef struct packed {
        logic               mag_zero;
        logic               rest_zero;
        logic [DIGIT_W-1:0] rem_digit;
        logic [DIGIT_W-1:0] slice_digit;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10)
            return CHAR_ZERO + dx;
        else if (upper)
            return CHAR_UPPER + dx - 8'd10;
        else
            return CHAR_LOWER + dx - 8'd10;
    endfunction

endpackage

// ===== src/itoa_ram.sv =====
// itoa_ram: generic single write port ram with registered read
// no dependencies

module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/itoa_div_unit.sv =====
// itoa_div_unit: shared magnitude register with a radix divider slice and a bit slicer
// depends on itoa_pkg

module itoa_div_unit (
    input  logic                               clk,
    input  itoa_pkg::div_ctrl_t                ctrl,
    input  logic [itoa_pkg::VALUE_W-1:0]       load_value,
    input  logic [itoa_pkg::RADIX_W-1:0]       radix,
    input  itoa_pkg::shift_t                   sh_sel,
    output itoa_pkg::div_stat_t                stat
);

    import itoa_pkg::*;

    logic [VALUE_W-1:0] d_reg, d_next;
    logic [DIGIT_W-1:0] r_reg, r_next;
    logic [VALUE_W-1:0] div_d;
    logic [DIGIT_W-1:0] div_r;
    logic [VALUE_W-1:0] slice_d;
    logic [DIGIT_W-1:0] slice_dig;

    // restoring division, a few quotient bits per cycle
    always_comb
    begin
        logic [DIGIT_W:0] t;
        div_d = d_reg;
        div_r = r_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t     = {div_r, div_d[VALUE_W-1]};
            div_d = {div_d[VALUE_W-2:0], 1'b0};
            if (t >= radix)
            begin
                t        = t - radix;
                div_d[0] = 1'b1;
            end
            div_r = t[DIGIT_W-1:0];
        end
    end

    always_comb
    begin
        case (sh_sel)
            SH_1:
            begin
                slice_d   = {1'b0, d_reg[VALUE_W-1:1]};
                slice_dig = {3'b000, d_reg[0]};
            end
            SH_3:
            begin
                slice_d   = {3'b000, d_reg[VALUE_W-1:3]};
                slice_dig = {1'b0, d_reg[2:0]};
            end
            SH_4:
            begin
                slice_d   = {4'b0000, d_reg[VALUE_W-1:4]};
                slice_dig = d_reg[3:0];
            end
            default:
            begin
                slice_d   = {4'b0000, d_reg[VALUE_W-1:4]};
                slice_dig = d_reg[3:0];
            end
        endcase
    end

    always_comb
    begin
        d_next = d_reg;
        r_next = r_reg;
        if (ctrl.load)
        begin
            d_next = load_value;
        end
        else if (ctrl.step)
        begin
            d_next = div_d;
            r_next = div_r;
        end
        else if (ctrl.slice)
        begin
            d_next = slice_d;
        end
        if (ctrl.clr_rem)
        begin
            r_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
        r_reg <= r_next;
    end

    assign stat.mag_zero    = (d_reg == '0);
    assign stat.rest_zero   = (slice_d == '0);
    assign stat.rem_digit   = r_reg;
    assign stat.slice_digit = slice_dig;

endmodule

// ===== src/integer_to_ascii_radix_core.sv =====
// integer_to_ascii_radix_core: radix 2..16 integer to ascii text, one character per item
// digits: radix 2, 8, 16 are sliced straight off the magnitude, other radices run the 4-bit
// divider slice and then store each digit, plus a minus sign; then a setup step, the pads,
// a step to prime the ram read and a read and load per digit out; pads and loads wait on output stalls
// one item at a time: in_ready rises once the last character is in the output register
// reset: rst_n clears sequencer and output valid, not the ram; uses pkg, ram and div unit

module integer_to_ascii_radix_core #(
    parameter int MAX_CHARS = itoa_pkg::MAX_CHARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  itoa_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output itoa_pkg::out_item_t out_data
);

    import itoa_pkg::*;

    localparam int LIMIT = (MAX_CHARS < RESULT_CAP) ? MAX_CHARS : RESULT_CAP;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIV   = 9'b000000010,
        S_DIGIT = 9'b000000100,
        S_SLICE = 9'b000001000,
        S_SIGN  = 9'b000010000,
        S_PREP  = 9'b000100000,
        S_PAD   = 9'b001000000,
        S_READ  = 9'b010000000,
        S_LOAD  = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [CNT_W-1:0]       pad_cnt_reg, pad_cnt_next;
    logic [ADDR_W-1:0]      rd_addr_reg, rd_addr_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MINLEN_W-1:0]    minlen_reg, minlen_next;
    logic [CHAR_W-1:0]      pad_reg, pad_next;
    logic                   upper_reg, upper_next;
    logic                   minus_reg, minus_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    shift_t                 sh_reg, sh_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_reg, out_next;

    logic                   accept;
    logic                   slot_free;
    logic                   load_out;
    logic [VALUE_W-1:0]     raw;
    logic [VALUE_W-1:0]     raw_neg;
    logic                   neg;
    logic                   pow2;
    logic [RADIX_W-1:0]     radix_c;
    logic [VALUE_W-1:0]     load_value;
    logic [CNT_W-1:0]       n_m1;

    div_ctrl_t              dctrl;
    div_stat_t              dstat;

    logic                   wr_en;
    logic [CHAR_W-1:0]      wr_data;
    logic [CHAR_W-1:0]      rd_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign n_m1      = n_reg - CNT_W'(1);

    // operand preparation at accept
    always_comb
    begin
        raw     = in_data.wide ? VALUE_W'(in_data.value)
                               : {{(VALUE_W-NARROW_W){1'b0}}, in_data.value[NARROW_W-1:0]};
        raw_neg = VALUE_W'(0) - raw;
        neg     = in_data.wide ? in_data.value[VALUE_W-1] : in_data.value[NARROW_W-1];
        if (in_data.radix < RADIX_MIN)
            radix_c = RADIX_MIN;
        else if (in_data.radix > RADIX_MAX)
            radix_c = RADIX_MAX;
        else
            radix_c = in_data.radix;
        pow2 = (radix_c == RADIX_MIN) || (radix_c == RADIX_OCT) || (radix_c == RADIX_MAX);
        if (in_data.signed_mode && neg && !pow2)
            load_value = in_data.wide ? raw_neg
                                      : {{(VALUE_W-NARROW_W){1'b0}}, raw_neg[NARROW_W-1:0]};
        else
            load_value = raw;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        pad_cnt_next   = pad_cnt_reg;
        rd_addr_next   = rd_addr_reg;
        cnt_next       = cnt_reg;
        minlen_next    = minlen_reg;
        pad_next       = pad_reg;
        upper_next     = upper_reg;
        minus_next     = minus_reg;
        radix_next     = radix_reg;
        sh_next        = sh_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        load_out       = 1'b0;
        dctrl          = '0;
        wr_en          = 1'b0;
        wr_data        = digit_char(dstat.rem_digit, upper_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next      = '0;
                    cnt_next    = '0;
                    minlen_next = (in_data.min_length > MINLEN_W'(LIMIT)) ? MINLEN_W'(LIMIT)
                                                                          : in_data.min_length;
                    pad_next    = in_data.fill_char;
                    upper_next  = in_data.upper_case;
                    minus_next  = in_data.signed_mode && neg && !pow2;
                    radix_next  = radix_c;
                    if (radix_c == RADIX_MIN)
                        sh_next = SH_1;
                    else if (radix_c == RADIX_OCT)
                        sh_next = SH_3;
                    else
                        sh_next = SH_4;
                    dctrl.load    = 1'b1;
                    dctrl.clr_rem = 1'b1;
                    state_next    = pow2 ? S_SLICE : S_DIV;
                end
            end
            S_DIV:
            begin
                dctrl.step = 1'b1;
                cnt_next   = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                wr_en   = 1'b1;
                wr_data = digit_char(dstat.rem_digit, upper_reg);
                n_next  = n_reg + CNT_W'(1);
                if (dstat.mag_zero)
                begin
                    state_next = minus_reg ? S_SIGN : S_PREP;
                end
                else
                begin
                    dctrl.clr_rem = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_SLICE:
            begin
                wr_en       = 1'b1;
                wr_data     = digit_char(dstat.slice_digit, upper_reg);
                dctrl.slice = 1'b1;
                n_next      = n_reg + CNT_W'(1);
                if (dstat.rest_zero)
                begin
                    state_next = S_PREP;
                end
            end
            S_SIGN:
            begin
                wr_en      = 1'b1;
                wr_data    = CHAR_MINUS;
                n_next     = n_reg + CNT_W'(1);
                state_next = S_PREP;
            end
            S_PREP:
            begin
                pad_cnt_next = (CNT_W'(minlen_reg) > n_reg) ? CNT_W'(minlen_reg) - n_reg : '0;
                rd_addr_next = n_m1[ADDR_W-1:0];
                state_next   = S_PAD;
            end
            S_PAD:
            begin
                if (pad_cnt_reg == '0)
                begin
                    state_next = S_LOAD;
                end
                else if (slot_free)
                begin
                    load_out      = 1'b1;
                    out_next      = '{char_out: pad_reg, last: 1'b0};
                    pad_cnt_next  = pad_cnt_reg - CNT_W'(1);
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    out_next = '{char_out: rd_data, last: (rd_addr_reg == '0)};
                    if (rd_addr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg - ADDR_W'(1);
                        state_next   = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        pad_cnt_reg <= pad_cnt_next;
        rd_addr_reg <= rd_addr_next;
        cnt_reg     <= cnt_next;
        minlen_reg  <= minlen_next;
        pad_reg     <= pad_next;
        upper_reg   <= upper_next;
        minus_reg   <= minus_next;
        radix_reg   <= radix_next;
        sh_reg      <= sh_next;
        out_reg     <= out_next;
    end

    itoa_div_unit u_div (
        .clk        (clk),
        .ctrl       (dctrl),
        .load_value (load_value),
        .radix      (radix_reg),
        .sh_sel     (sh_next),
        .stat       (dstat)
    );

    itoa_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (RESULT_CAP)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (n_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (n_reg <= CNT_W'(RESULT_CAP)))
        else $error("character count beyond buffer");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> ({1'b0, rd_addr_reg} < n_reg))
        else $error("read address outside stored text");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && out_next.last) |=> (state_reg == S_IDLE))
        else $error("last character sent without returning to idle");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && slot_free) |=> out_valid)
        else $error("digit load lost");
`endif

endmodule
